// ===== sv/lppw_pkg.sv =====
// ----------------------------------------------------------------------------
// lppw_pkg
// Shared constants and result codes for the line point walker.
// ----------------------------------------------------------------------------
`default_nettype none

package lppw_pkg;

  // operation codes on the input channel
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // result kind codes
  typedef enum logic [2:0] {
    KIND_START_OK  = 3'd0,
    KIND_START_REJ = 3'd1,
    KIND_INSIDE    = 3'd2,
    KIND_OUTSIDE   = 3'd3,
    KIND_IDLE      = 3'd4
  } kind_t;

  // configuration register indexes
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  localparam int SIZE_W  = 13;
  localparam int POINT_W = 12;
  localparam int ADDR_W  = 24;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

endpackage

`default_nettype wire

// ===== sv/line_profile_point_walker.sv =====
// ----------------------------------------------------------------------------
// line_profile_point_walker
// Walks the points of a line segment one x column per step, x-major style.
// ----------------------------------------------------------------------------
// Usage: write image_cols (index 0) and image_rows (index 1) on the cfg
// channel while the block is idle; cfg_ready is always high. On the input
// channel a start transfer (operation 0) carries both endpoints and returns
// one result: accepted or rejected. Each step transfer (operation 1) returns
// one result: a point inside the image with its linear address, a point
// outside the image (skipped), or idle when no line is active. out_last
// marks the result after which no further point remains.
// The result of each input transfer is registered in the output register;
// one item is taken every cycle while in_stall is low, the step arithmetic
// and the 13x13 address multiply sitting between the line state and the
// output register. While out_stall holds a waiting result, in_stall is
// raised and the held result does not change. Reset drops any active line,
// empties the output register and sets both image sizes to 4096.
// ----------------------------------------------------------------------------
`default_nettype none

module line_profile_point_walker #(
  parameter int COORD_BITS = 13
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // configuration
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire                            cfg_index,
  input  wire  [lppw_pkg::SIZE_W-1:0]    cfg_data,
  // input channel
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire                            in_operation,
  input  wire  signed [COORD_BITS-1:0]   in_x_start,
  input  wire  signed [COORD_BITS-1:0]   in_y_start,
  input  wire  signed [COORD_BITS-1:0]   in_x_end,
  input  wire  signed [COORD_BITS-1:0]   in_y_end,
  // result channel
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [2:0]                     out_kind,
  output logic [lppw_pkg::POINT_W-1:0]   out_point_x,
  output logic [lppw_pkg::POINT_W-1:0]   out_point_y,
  output logic [lppw_pkg::ADDR_W-1:0]    out_pixel_address,
  output logic                           out_last
);

  localparam int SW     = lppw_pkg::SIZE_W;
  localparam int PW     = lppw_pkg::POINT_W;
  localparam int AW     = lppw_pkg::ADDR_W;
  localparam int ERR_W  = COORD_BITS + 3;
  localparam int CMP_W  = ((COORD_BITS > SW) ? COORD_BITS : SW) + 2;
  localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};

  // configuration registers
  logic [SW-1:0] cols_r;
  logic [SW-1:0] rows_r;

  // line state
  logic                          active_r, active_nxt;
  logic signed [COORD_BITS-1:0]  cur_x_r, cur_x_nxt;
  logic signed [COORD_BITS-1:0]  cur_y_r, cur_y_nxt;
  logic signed [COORD_BITS-1:0]  stop_x_r, stop_x_nxt;
  logic signed [ERR_W-1:0]       err_r, err_nxt;
  logic [COORD_BITS:0]           inc_flat_r, inc_flat_nxt;
  logic signed [COORD_BITS+1:0]  inc_diag_r, inc_diag_nxt;
  logic                          y_down_r, y_down_nxt;

  // output register
  logic            out_valid_r;
  lppw_pkg::kind_t kind_r, kind_nxt;
  logic [PW-1:0]   px_r, px_nxt;
  logic [PW-1:0]   py_r, py_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic            last_r, last_nxt;

  logic in_xfer;

  // start setup
  logic signed [CMP_W-1:0]       x2_cmp, y2_cmp, cols_cmp, rows_cmp;
  logic                          reject;
  logic signed [COORD_BITS:0]    diff_x, diff_y;
  logic [COORD_BITS-1:0]         dx, dy;
  logic signed [COORD_BITS+1:0]  dy_minus_dx;
  logic signed [ERR_W-1:0]       err_init;
  logic                          swap;
  logic signed [COORD_BITS-1:0]  sx, sy, ex, ey;

  // step
  logic                          go_diag;
  logic signed [ERR_W:0]         err_sum;
  logic signed [ERR_W-1:0]       err_step;
  logic signed [COORD_BITS-1:0]  nx, ny;
  logic signed [CMP_W-1:0]       nx_cmp, ny_cmp;
  logic                          on_image;
  logic [2*SW-1:0]               row_base;
  logic [2*SW-1:0]               addr_full;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_xfer   = in_valid && !in_stall;

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_point_x       = px_r;
  assign out_point_y       = py_r;
  assign out_pixel_address = addr_r;
  assign out_last          = last_r;

  // start: bounds check and Bresenham setup
  always_comb begin
    x2_cmp   = CMP_W'(in_x_end);
    y2_cmp   = CMP_W'(in_y_end);
    cols_cmp = $signed(CMP_W'(cols_r));
    rows_cmp = $signed(CMP_W'(rows_r));
    reject   = in_x_start[COORD_BITS-1] || in_y_start[COORD_BITS-1] ||
               (x2_cmp > cols_cmp) || (y2_cmp > rows_cmp);

    diff_x = (COORD_BITS+1)'(in_x_end) - (COORD_BITS+1)'(in_x_start);
    diff_y = (COORD_BITS+1)'(in_y_end) - (COORD_BITS+1)'(in_y_start);
    dx = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : COORD_BITS'(diff_x);
    dy = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : COORD_BITS'(diff_y);
    dy_minus_dx = $signed((COORD_BITS+2)'(dy)) - $signed((COORD_BITS+2)'(dx));
    err_init = $signed(ERR_W'({dy, 1'b0})) - $signed(ERR_W'(dx));

    // leftmost endpoint becomes the start point
    swap = in_x_start > in_x_end;
    sx   = swap ? in_x_end   : in_x_start;
    sy   = swap ? in_y_end   : in_y_start;
    ex   = swap ? in_x_start : in_x_end;
    ey   = swap ? in_y_start : in_y_end;
  end

  // step: advance x, update error and y
  always_comb begin
    go_diag = !err_r[ERR_W-1];
    err_sum = go_diag ? ((ERR_W+1)'(err_r) + (ERR_W+1)'(inc_diag_r))
                      : ((ERR_W+1)'(err_r) + $signed((ERR_W+1)'(inc_flat_r)));
    if (err_sum[ERR_W] != err_sum[ERR_W-1]) begin
      err_step = err_sum[ERR_W] ? ERR_MIN : ERR_MAX;
    end else begin
      err_step = err_sum[ERR_W-1:0];
    end

    nx = cur_x_r + COORD_BITS'(1);
    if (go_diag) begin
      ny = y_down_r ? (cur_y_r - COORD_BITS'(1)) : (cur_y_r + COORD_BITS'(1));
    end else begin
      ny = cur_y_r;
    end
    nx_cmp = CMP_W'(nx);
    ny_cmp = CMP_W'(ny);
    on_image = !nx_cmp[CMP_W-1] && !ny_cmp[CMP_W-1] &&
               (nx_cmp < cols_cmp) && (ny_cmp < rows_cmp);

    // both coordinates are below 8192 whenever the point is inside
    row_base  = (2*SW)'(ny_cmp[SW-1:0]) * (2*SW)'(cols_r);
    addr_full = row_base + (2*SW)'(nx_cmp[SW-1:0]);
  end

  always_comb begin
    active_nxt   = active_r;
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    stop_x_nxt   = stop_x_r;
    err_nxt      = err_r;
    inc_flat_nxt = inc_flat_r;
    inc_diag_nxt = inc_diag_r;
    y_down_nxt   = y_down_r;
    kind_nxt     = lppw_pkg::KIND_IDLE;
    px_nxt       = '0;
    py_nxt       = '0;
    addr_nxt     = '0;
    last_nxt     = 1'b1;

    if (in_operation == lppw_pkg::OP_START) begin
      if (reject) begin
        kind_nxt   = lppw_pkg::KIND_START_REJ;
        active_nxt = 1'b0;
      end else begin
        kind_nxt     = lppw_pkg::KIND_START_OK;
        inc_flat_nxt = {dy, 1'b0};
        inc_diag_nxt = {dy_minus_dx[COORD_BITS:0], 1'b0};
        err_nxt      = err_init;
        cur_x_nxt    = sx;
        cur_y_nxt    = sy;
        stop_x_nxt   = ex;
        y_down_nxt   = !(sy < ey);
        active_nxt   = sx < ex;
        last_nxt     = !(sx < ex);
      end
    end else if (active_r) begin
      cur_x_nxt  = nx;
      cur_y_nxt  = ny;
      err_nxt    = err_step;
      active_nxt = nx < stop_x_r;
      last_nxt   = !(nx < stop_x_r);
      if (on_image) begin
        kind_nxt = lppw_pkg::KIND_INSIDE;
        px_nxt   = nx_cmp[PW-1:0];
        py_nxt   = ny_cmp[PW-1:0];
        addr_nxt = addr_full[AW-1:0];
      end else begin
        kind_nxt = lppw_pkg::KIND_OUTSIDE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r      <= lppw_pkg::SIZE_RESET;
      rows_r      <= lppw_pkg::SIZE_RESET;
      active_r    <= 1'b0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      stop_x_r    <= '0;
      err_r       <= '0;
      inc_flat_r  <= '0;
      inc_diag_r  <= '0;
      y_down_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lppw_pkg::REG_COLS: cols_r <= cfg_data;
          lppw_pkg::REG_ROWS: rows_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_xfer) begin
        active_r   <= active_nxt;
        cur_x_r    <= cur_x_nxt;
        cur_y_r    <= cur_y_nxt;
        stop_x_r   <= stop_x_nxt;
        err_r      <= err_nxt;
        inc_flat_r <= inc_flat_nxt;
        inc_diag_r <= inc_diag_nxt;
        y_down_r   <= y_down_nxt;
      end
      // result register loads on a transfer, empties when taken
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r <= kind_nxt;
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      addr_r <= addr_nxt;
      last_r <= last_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line point walker. A scoreboard class predicts
// every result from the accepted transfers and checks the results in order.
// Plain tasks drive directed corner lines first, then random line walks under
// several image sizes, idle and stall patterns, a long output hold-off and a
// full drain pause.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int CB = 13;

  typedef struct packed {
    lppw_pkg::kind_t                kind;
    logic [lppw_pkg::POINT_W-1:0]   px;
    logic [lppw_pkg::POINT_W-1:0]   py;
    logic [lppw_pkg::ADDR_W-1:0]    addr;
    logic                           last;
  } walk_result_t;

  class point_scoreboard;
    int  cols;
    int  rows;
    bit  active;
    bit  down;
    int  cx;
    int  cy;
    int  stop_x;
    int  err;
    int  inc_flat;
    int  inc_diag;
    int  fails;
    walk_result_t expected_points[$];

    function new();
      cols = 4096;
      rows = 4096;
      active = 0;
      down = 0;
      cx = 0;
      cy = 0;
      stop_x = 0;
      err = 0;
      inc_flat = 0;
      inc_diag = 0;
      fails = 0;
    endfunction

    function void set_size(logic idx, int val);
      if (idx == lppw_pkg::REG_COLS) begin
        cols = val & 'h1FFF;
      end else begin
        rows = val & 'h1FFF;
      end
    endfunction

    // error term is held in COORD_BITS+3 signed bits
    function int clip_err(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    function void take_item(logic op, int x1, int y1, int x2, int y2);
      walk_result_t r;
      int dx, dy, sy, ey;
      r.kind = lppw_pkg::KIND_IDLE;
      r.px = '0;
      r.py = '0;
      r.addr = '0;
      r.last = 1'b1;
      if (op == lppw_pkg::OP_START) begin
        if (x1 < 0 || x2 > cols || y1 < 0 || y2 > rows) begin
          r.kind = lppw_pkg::KIND_START_REJ;
          active = 0;
        end else begin
          dx = (x2 > x1) ? x2 - x1 : x1 - x2;
          dy = (y2 > y1) ? y2 - y1 : y1 - y2;
          inc_flat = 2 * dy;
          inc_diag = 2 * (dy - dx);
          err = clip_err(2 * dy - dx);
          // walk always runs left to right
          if (x1 > x2) begin
            cx = x2; cy = y2; stop_x = x1; sy = y2; ey = y1;
          end else begin
            cx = x1; cy = y1; stop_x = x2; sy = y1; ey = y2;
          end
          down = !(sy < ey);
          active = cx < stop_x;
          r.kind = lppw_pkg::KIND_START_OK;
          r.last = !active;
        end
      end else if (active) begin
        cx = cx + 1;
        if (err < 0) begin
          err = clip_err(err + inc_flat);
        end else begin
          cy = down ? cy - 1 : cy + 1;
          err = clip_err(err + inc_diag);
        end
        if (cx >= 0 && cx < cols && cy >= 0 && cy < rows) begin
          r.kind = lppw_pkg::KIND_INSIDE;
          r.px = cx[lppw_pkg::POINT_W-1:0];
          r.py = cy[lppw_pkg::POINT_W-1:0];
          r.addr = 24'(cy * cols + cx);
        end else begin
          r.kind = lppw_pkg::KIND_OUTSIDE;
        end
        active = cx < stop_x;
        r.last = !active;
      end
      expected_points.insert(expected_points.size(), r);
    endfunction

    function void check_point(logic [2:0] kind,
                              logic [lppw_pkg::POINT_W-1:0] px,
                              logic [lppw_pkg::POINT_W-1:0] py,
                              logic [lppw_pkg::ADDR_W-1:0] addr,
                              logic last);
      walk_result_t e;
      if (expected_points.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result: kind %0d x %0d y %0d", kind, px, py);
        return;
      end
      e = expected_points.pop_front();
      if (kind !== e.kind || px !== e.px || py !== e.py || addr !== e.addr ||
          last !== e.last) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: exp kind %0d x %0d y %0d addr %0d last %0d, %s %0d %0d %0d %0d %0d",
                   e.kind, e.px, e.py, e.addr, e.last, "got",
                   kind, px, py, addr, last);
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic                            cfg_index;
  logic [lppw_pkg::SIZE_W-1:0]     cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic                            in_operation;
  logic signed [CB-1:0]            in_x_start;
  logic signed [CB-1:0]            in_y_start;
  logic signed [CB-1:0]            in_x_end;
  logic signed [CB-1:0]            in_y_end;
  logic                            out_valid;
  logic                            out_stall;
  logic [2:0]                      out_kind;
  logic [lppw_pkg::POINT_W-1:0]    out_point_x;
  logic [lppw_pkg::POINT_W-1:0]    out_point_y;
  logic [lppw_pkg::ADDR_W-1:0]     out_pixel_address;
  logic                            out_last;

  point_scoreboard sb;
  int send_idle_pct;
  int stall_pct;
  bit hold_req;
  int hold_left;
  int items_sent;

  line_profile_point_walker #(.COORD_BITS(CB)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_x_start        (in_x_start),
    .in_y_start        (in_y_start),
    .in_x_end          (in_x_end),
    .in_y_end          (in_y_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_point_x       (out_point_x),
    .out_point_y       (out_point_y),
    .out_pixel_address (out_pixel_address),
    .out_last          (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #800000;
    $display("FAIL");
    $finish;
  end

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 0;
        hold_left = 300;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_point(out_kind, out_point_x, out_point_y, out_pixel_address, out_last);
  end

  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 8191)) - 4096;
  endfunction

  function automatic void set_idle(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 63; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 63; end
      default: begin send_idle_pct = 16; stall_pct = 16; end
    endcase
  endfunction

  task automatic send_item(logic op, int xs, int ys, int xe, int ye);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_x_start   <= xs[CB-1:0];
    in_y_start   <= ys[CB-1:0];
    in_x_end     <= xe[CB-1:0];
    in_y_end     <= ye[CB-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_item(op, xs, ys, xe, ye);
    items_sent++;
  endtask

  // endpoint fields carry junk on steps
  task automatic send_step();
    send_item(lppw_pkg::OP_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_all_points();
    release_input();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[lppw_pkg::SIZE_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_size(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_sizes(int c, int r);
    wait_all_points();
    write_reg(lppw_pkg::REG_COLS, c);
    write_reg(lppw_pkg::REG_ROWS, r);
  endtask

  // one start with the steps that walk it, or a piece of noise
  task automatic random_burst();
    int r, x1, y1, x2, y2, len, dy, n, xmax, ymax;
    xmax = clamp(sb.cols, 0, 4095);
    ymax = clamp(sb.rows, 0, 4095);
    x1 = $urandom_range(0, clamp(sb.cols + 2, 0, 4095));
    y1 = $urandom_range(0, clamp(sb.rows + 2, 0, 4095));
    r = $urandom_range(0, 99);
    if (r < 8) begin
      send_item(lppw_pkg::OP_START, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    end else if (r < 14) begin
      send_step();
    end else if (r < 20) begin
      // start that breaks exactly one bound
      x2 = $urandom_range(0, xmax);
      y2 = $urandom_range(0, ymax);
      case ($urandom_range(0, 3))
        0: x1 = -int'($urandom_range(1, 4096));
        1: y1 = -int'($urandom_range(1, 4096));
        2: begin
          if (sb.cols < 4095) x2 = $urandom_range(sb.cols + 1, 4095);
          else x1 = -1;
        end
        default: begin
          if (sb.rows < 4095) y2 = $urandom_range(sb.rows + 1, 4095);
          else y1 = -1;
        end
      endcase
      send_item(lppw_pkg::OP_START, x1, y1, x2, y2);
    end else begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      x2 = clamp($urandom_range(0, 1) ? x1 + len : x1 - len, -4096, xmax);
      r = $urandom_range(0, 9);
      if (r < 7) dy = $urandom_range(0, len + 2);
      else if (r < 9) dy = $urandom_range(len, len * 4 + 8);
      else dy = $urandom_range(len + 1, 8191);
      y2 = clamp($urandom_range(0, 1) ? y1 + dy : y1 - dy, -4096, ymax);
      send_item(lppw_pkg::OP_START, x1, y1, x2, y2);
      n = (x2 > x1) ? x2 - x1 : x1 - x2;
      r = $urandom_range(0, 99);
      if (r < 15) n = $urandom_range(0, n);
      else if (r < 30) n = n + $urandom_range(1, 2);
      repeat (n) send_step();
    end
  endtask

  initial begin
    int cols_pick[8];
    int rows_pick[8];
    int phase_start;
    int guard;
    bit paused;
    bit held;
    sb = new();
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_operation = 1'b0;
    in_x_start = '0;
    in_y_start = '0;
    in_x_end = '0;
    in_y_end = '0;
    hold_req = 0;
    items_sent = 0;
    set_idle(0);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed corners under the reset image size
    send_step();
    send_item(lppw_pkg::OP_START, -1, 0, 3, 3);
    send_item(lppw_pkg::OP_START, 0, -4096, 3, 3);
    send_item(lppw_pkg::OP_START, 4095, 4095, 4095, 4095);
    send_step();
    send_item(lppw_pkg::OP_START, 0, 0, -4096, -4096);
    send_step();
    send_step();
    // steep line downward, error term saturates
    send_item(lppw_pkg::OP_START, 0, 4095, 5, -4096);
    repeat (5) send_step();
    // last pixel of the image, largest address
    send_item(lppw_pkg::OP_START, 4095, 4095, 4094, 4094);
    send_step();
    set_sizes(100, 50);
    send_item(lppw_pkg::OP_START, 0, 0, 101, 0);
    send_item(lppw_pkg::OP_START, 0, 0, 0, 51);
    send_item(lppw_pkg::OP_START, 98, 48, 100, 50);
    send_step();
    send_step();
    send_item(lppw_pkg::OP_START, 3, 3, 1, 1);
    send_step();
    // restart while a line is active, flat line with negative error
    send_item(lppw_pkg::OP_START, 0, 0, 10, 3);
    send_step();

    cols_pick = '{4096, 16, 0, 8191, 1, 40, 0, 4095};
    rows_pick = '{4096, 12, 20, 8191, 1, 0, 0, 64};
    cols_pick[6] = $urandom_range(1, 4096);
    rows_pick[6] = $urandom_range(1, 4096);
    for (int p = 0; p < 8; p++) begin
      set_sizes(cols_pick[p], rows_pick[p]);
      set_idle(p % 4);
      phase_start = items_sent;
      paused = 0;
      held = 0;
      while (items_sent < phase_start + 180) begin
        // long output hold-off while the sender keeps pushing
        if (!held && p % 4 == 0 && items_sent >= phase_start + 50) begin
          hold_req = 1;
          held = 1;
        end
        if (!paused && items_sent >= phase_start + 110) begin
          wait_all_points();
          paused = 1;
        end
        random_burst();
      end
    end

    release_input();
    guard = 0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) $display("%0d results never arrived", sb.pending());
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
